### rtl/core/svpwm_pkg.sv
package svpwm_pkg;

    // Unsigned Q30 values used by the sine evaluation.
    localparam int Q30_W = 31;
    typedef logic [Q30_W-1:0] q30_t;

    localparam q30_t Q30_ONE  = 31'h4000_0000;
    localparam q30_t PI3_Q30  = 31'd1124419809;
    localparam q30_t K2S3_Q30 = 31'd1239850262;

    localparam int HORNER_STEPS = 5;
    localparam int CELL_STAGES  = 3;
    // x, x squared, Horner cells, sine product, gain product, rounding.
    localparam int LANE_STAGES  = 2 + HORNER_STEPS * CELL_STAGES + 3;

    localparam logic [15:0] RESET_PERIOD = 16'd718;

    typedef logic [15:0] period_t;

    typedef struct packed {
        logic        [15:0] vector_angle;
        logic signed [15:0] modulation;
    } request_t;

    typedef struct packed {
        logic [15:0] compare_u;
        logic [15:0] compare_v;
        logic [15:0] compare_w;
        logic [2:0]  sector_index;
    } result_t;

    // Data handed from one Horner cell to the next.
    typedef struct packed {
        q30_t x;
        q30_t x2;
        q30_t t;
    } horner_lane_t;

    // Divisors of the Taylor series, from the innermost term outward.
    function automatic int unsigned horner_div(input int step);
        int unsigned div;
        case (step)
            0:       div = 110;
            1:       div = 72;
            2:       div = 42;
            3:       div = 20;
            default: div = 6;
        endcase
        return div;
    endfunction

endpackage

### rtl/core/svpwm_chan.sv
interface svpwm_chan #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

### rtl/core/svpwm_horner_cell.sv
module svpwm_horner_cell
    import svpwm_pkg::*;
#(
    parameter int unsigned DIVISOR = 6
)
(
    input  logic         clk,
    input  logic         en,
    input  horner_lane_t lane_in,
    output horner_lane_t lane_out
);

    // floor(y / DIVISOR) for any 31-bit y as a multiply by a rounded-up reciprocal.
    localparam int SHIFT_L = $clog2(DIVISOR);
    localparam int QSHIFT  = Q30_W + SHIFT_L;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << QSHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [31:0] RECIP = RECIP_FULL[31:0];

    logic [2*Q30_W-1:0] prod_next;
    logic [2*Q30_W-1:0] prod_reg;
    logic [2*Q30_W:0]   quo_next;
    logic [2*Q30_W:0]   quo_reg;
    logic [2*Q30_W:0]   quo_shift;
    q30_t               s1_x_reg;
    q30_t               s1_x2_reg;
    q30_t               s2_x_reg;
    q30_t               s2_x2_reg;
    q30_t               t_next;
    horner_lane_t       out_reg;

    assign prod_next = (2*Q30_W)'(lane_in.x2) * (2*Q30_W)'(lane_in.t);
    assign quo_next  = (2*Q30_W+1)'(prod_reg[2*Q30_W-2:Q30_W-1]) * (2*Q30_W+1)'(RECIP);
    assign quo_shift = quo_reg >> QSHIFT;
    assign t_next    = Q30_ONE - quo_shift[Q30_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            s1_x_reg  <= lane_in.x;
            s1_x2_reg <= lane_in.x2;
            quo_reg   <= quo_next;
            s2_x_reg  <= s1_x_reg;
            s2_x2_reg <= s1_x2_reg;
            out_reg   <= '{x: s2_x_reg, x2: s2_x2_reg, t: t_next};
        end
    end

    assign lane_out = out_reg;

endmodule

### rtl/core/svpwm_sine_lane.sv
module svpwm_sine_lane
    import svpwm_pkg::*;
#(
    parameter int ANGLE_BITS     = 16,
    parameter int SINE_FRAC_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    en,
    input  logic [ANGLE_BITS:0]     f,
    output logic [SINE_FRAC_BITS:0] gain
);

    localparam int XP_W = ANGLE_BITS + 1 + Q30_W;
    localparam int RSH  = Q30_W - 1 - SINE_FRAC_BITS;
    localparam logic [Q30_W:0] GAIN_ONE = (Q30_W+1)'(1) << SINE_FRAC_BITS;

    logic [XP_W-1:0]         xf_prod;
    logic [2*Q30_W-1:0]      sq_prod;
    logic [2*Q30_W-1:0]      s_prod;
    logic [2*Q30_W-1:0]      g_prod;
    logic [Q30_W:0]          g_round;
    logic [Q30_W:0]          g_shift;
    logic [SINE_FRAC_BITS:0] gain_next;
    q30_t                    x_reg;
    q30_t                    sq_x_reg;
    q30_t                    sq_x2_reg;
    q30_t                    s_reg;
    q30_t                    g_reg;
    logic [SINE_FRAC_BITS:0] gain_reg;
    horner_lane_t            chain [HORNER_STEPS+1];

    // Radian argument in Q30: sixty degrees maps to pi/3.
    assign xf_prod = XP_W'(f) * XP_W'(PI3_Q30);
    assign sq_prod = (2*Q30_W)'(x_reg) * (2*Q30_W)'(x_reg);

    assign chain[0] = '{x: sq_x_reg, x2: sq_x2_reg, t: Q30_ONE};

    for (genvar i = 0; i < HORNER_STEPS; i++)
    begin : g_cell
        svpwm_horner_cell #(
            .DIVISOR (horner_div(i))
        ) u_cell (
            .clk      (clk),
            .en       (en),
            .lane_in  (chain[i]),
            .lane_out (chain[i+1])
        );
    end

    assign s_prod  = (2*Q30_W)'(chain[HORNER_STEPS].x) * (2*Q30_W)'(chain[HORNER_STEPS].t);
    assign g_prod  = (2*Q30_W)'(s_reg) * (2*Q30_W)'(K2S3_Q30);
    assign g_round = (Q30_W+1)'(g_reg) + ((Q30_W+1)'(1) << (RSH - 1));
    assign g_shift = g_round >> RSH;
    assign gain_next = (g_shift > GAIN_ONE) ? GAIN_ONE[SINE_FRAC_BITS:0]
                                            : g_shift[SINE_FRAC_BITS:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg     <= xf_prod[ANGLE_BITS +: Q30_W];
            sq_x_reg  <= x_reg;
            sq_x2_reg <= sq_prod[2*Q30_W-2:Q30_W-1];
            s_reg     <= s_prod[2*Q30_W-2:Q30_W-1];
            g_reg     <= g_prod[2*Q30_W-2:Q30_W-1];
            gain_reg  <= gain_next;
        end
    end

    assign gain = gain_reg;

endmodule

### rtl/core/space_vector_pwm_duty.sv
// Throughput: one transaction per cycle; the pipeline moves as a whole and stalls
// only when the two-entry output buffer is full.
// The depth is set by the two sine lanes: five Horner cells of three stages each.
// Reset (rst_n, asynchronous, active low) empties the pipeline and output buffer
// and sets period_reg to 718.
module space_vector_pwm_duty
    import svpwm_pkg::*;
#(
    parameter int ANGLE_BITS     = 16,
    parameter int SINE_FRAC_BITS = 16
)
(
    input logic       clk,
    input logic       rst_n,
    svpwm_chan.sink   request,
    svpwm_chan.source result,
    svpwm_chan.sink   cfg
);

    localparam int AW = ANGLE_BITS;
    localparam int FW = SINE_FRAC_BITS;
    localparam int DW = FW + 3;
    localparam int PIPE_STAGES = LANE_STAGES + 4;

    localparam logic [2:0] SECTOR_0 = 3'd0;
    localparam logic [2:0] SECTOR_1 = 3'd1;
    localparam logic [2:0] SECTOR_2 = 3'd2;
    localparam logic [2:0] SECTOR_3 = 3'd3;
    localparam logic [2:0] SECTOR_4 = 3'd4;
    localparam logic [2:0] SECTOR_5 = 3'd5;

    localparam logic signed [DW-1:0] DUTY_ONE = DW'(1) << FW;
    localparam logic signed [DW-1:0] DUTY_TWO = DW'(1) << (FW + 1);

    typedef struct packed {
        logic [15:0] mag;
        logic [2:0]  sector;
    } side_t;

    function automatic logic [15:0] scale_duty(input logic signed [DW-1:0] duty,
                                               input logic [15:0] period);
        logic [FW+16:0] prod;
        logic [15:0]    cmp;
        prod = (FW+17)'(duty[FW:0]) * (FW+17)'(period);
        if (duty <= 0)
            cmp = 16'd0;
        else if (duty >= DUTY_TWO)
            cmp = period;
        else
            cmp = prod[FW+1 +: 16];
        return cmp;
    endfunction

    // Configuration.
    period_t period_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            period_reg <= RESET_PERIOD;
        else if (cfg.valid)
            period_reg <= cfg.data;
    end

    // Pipeline control: every stage advances together.
    logic                   adv;
    logic [PIPE_STAGES-1:0] vld_reg;
    logic                   out_vld_reg;
    logic                   skid_vld_reg;
    result_t                out_reg;
    result_t                skid_reg;

    assign adv           = !skid_vld_reg;
    assign request.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[PIPE_STAGES-2:0], request.valid};
    end

    // Angle preparation: sector and position within the sector.
    logic [15+AW:0] angle_wide;
    logic [AW-1:0]  angle_raw;
    logic [AW-1:0]  angle;
    logic           neg;
    logic [15:0]    mag_next;
    logic [AW+2:0]  pos;
    logic [2:0]     sector_raw;
    logic [2:0]     sector_next;
    logic [AW:0]    fa_next;
    logic [AW:0]    fb_next;
    logic [AW:0]    fa_reg;
    logic [AW:0]    fb_reg;
    side_t          s0_side_reg;

    assign angle_wide  = (16+AW)'(request.data.vector_angle) << AW;
    assign angle_raw   = angle_wide[16 +: AW];
    assign neg         = request.data.modulation[15];
    // Adding half a turn only toggles the top angle bit.
    assign angle       = angle_raw ^ {neg, {(AW-1){1'b0}}};
    assign mag_next    = neg ? (16'd0 - request.data.modulation) : request.data.modulation;
    assign pos         = ({3'b000, angle} << 2) + ({3'b000, angle} << 1);
    assign sector_raw  = pos[AW+2:AW];
    assign sector_next = (sector_raw > SECTOR_5) ? SECTOR_5 : sector_raw;
    assign fb_next     = {1'b0, pos[AW-1:0]};
    assign fa_next     = {1'b1, {AW{1'b0}}} - fb_next;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fa_reg      <= fa_next;
            fb_reg      <= fb_next;
            s0_side_reg <= '{mag: mag_next, sector: sector_next};
        end
    end

    // Two gain lanes: timeA uses the distance to the sector end, timeB the position.
    logic [FW:0] gain_a;
    logic [FW:0] gain_b;

    svpwm_sine_lane #(
        .ANGLE_BITS     (ANGLE_BITS),
        .SINE_FRAC_BITS (SINE_FRAC_BITS)
    ) u_lane_a (
        .clk  (clk),
        .en   (adv),
        .f    (fa_reg),
        .gain (gain_a)
    );

    svpwm_sine_lane #(
        .ANGLE_BITS     (ANGLE_BITS),
        .SINE_FRAC_BITS (SINE_FRAC_BITS)
    ) u_lane_b (
        .clk  (clk),
        .en   (adv),
        .f    (fb_reg),
        .gain (gain_b)
    );

    side_t side_reg [LANE_STAGES];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= s0_side_reg;
            for (int i = 1; i < LANE_STAGES; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Active vector times.
    logic [FW+16:0] ta_prod;
    logic [FW+16:0] tb_prod;
    logic [FW:0]    ta_reg;
    logic [FW:0]    tb_reg;
    logic [2:0]     t_sector_reg;

    assign ta_prod = (FW+17)'(side_reg[LANE_STAGES-1].mag) * (FW+17)'(gain_a);
    assign tb_prod = (FW+17)'(side_reg[LANE_STAGES-1].mag) * (FW+17)'(gain_b);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ta_reg       <= ta_prod[15 +: FW+1];
            tb_reg       <= tb_prod[15 +: FW+1];
            t_sector_reg <= side_reg[LANE_STAGES-1].sector;
        end
    end

    // Phase duties in Q(FW+1); the half zero time may go negative when overmodulated.
    logic signed [DW-1:0] ta_s;
    logic signed [DW-1:0] tb_s;
    logic signed [DW-1:0] t02;
    logic signed [DW-1:0] lo;
    logic signed [DW-1:0] hi;
    logic signed [DW-1:0] mid;
    logic signed [DW-1:0] du_next;
    logic signed [DW-1:0] dv_next;
    logic signed [DW-1:0] dw_next;
    logic signed [DW-1:0] du_reg;
    logic signed [DW-1:0] dv_reg;
    logic signed [DW-1:0] dw_reg;
    logic [2:0]           d_sector_reg;

    assign ta_s = signed'(DW'(ta_reg));
    assign tb_s = signed'(DW'(tb_reg));
    assign t02  = DUTY_ONE - ta_s - tb_s;
    assign lo   = t02;
    assign hi   = DUTY_TWO - t02;
    assign mid  = t02 + (t_sector_reg[0] ? (tb_s <<< 1) : (ta_s <<< 1));

    always_comb
    begin
        case (t_sector_reg)
            SECTOR_0:
            begin
                du_next = lo;  dv_next = mid; dw_next = hi;
            end
            SECTOR_1:
            begin
                du_next = mid; dv_next = lo;  dw_next = hi;
            end
            SECTOR_2:
            begin
                du_next = hi;  dv_next = lo;  dw_next = mid;
            end
            SECTOR_3:
            begin
                du_next = hi;  dv_next = mid; dw_next = lo;
            end
            SECTOR_4:
            begin
                du_next = mid; dv_next = hi;  dw_next = lo;
            end
            default:
            begin
                du_next = lo;  dv_next = hi;  dw_next = mid;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            du_reg       <= du_next;
            dv_reg       <= dv_next;
            dw_reg       <= dw_next;
            d_sector_reg <= t_sector_reg;
        end
    end

    // Compare values.
    result_t fin_next;
    result_t fin_reg;

    assign fin_next = '{compare_u:    scale_duty(du_reg, period_reg),
                        compare_v:    scale_duty(dv_reg, period_reg),
                        compare_w:    scale_duty(dw_reg, period_reg),
                        sector_index: d_sector_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
            fin_reg <= fin_next;
    end

    // Output register plus skid entry, so the pipeline keeps moving for one
    // more result while the consumer stalls.
    logic fin_move;

    assign fin_move = adv && vld_reg[PIPE_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (result.ready)
                skid_vld_reg <= 1'b0;
        end
        else if (fin_move)
        begin
            if (out_vld_reg && !result.ready)
                skid_vld_reg <= 1'b1;
            else
                out_vld_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (result.ready)
                out_reg <= skid_reg;
        end
        else if (fin_move)
        begin
            if (out_vld_reg && !result.ready)
                skid_reg <= fin_reg;
            else
                out_reg <= fin_reg;
        end
    end

    assign result.valid = out_vld_reg;
    assign result.data  = out_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid entry holds a result while the output register is empty");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

    a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.data.compare_u <= period_reg &&
                          result.data.compare_v <= period_reg &&
                          result.data.compare_w <= period_reg))
        else $error("compare value above the period");

    a_sector0_order: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.sector_index == SECTOR_0 |->
            (result.data.compare_u <= result.data.compare_v &&
             result.data.compare_v <= result.data.compare_w))
        else $error("sector zero phases out of order");

    a_sector3_order: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.sector_index == SECTOR_3 |->
            (result.data.compare_u >= result.data.compare_v &&
             result.data.compare_v >= result.data.compare_w))
        else $error("sector three phases out of order");

endmodule
